/* rtl/hse_pkg.sv */
// Shared types and codes for the Hack-style instruction execute unit.
// Depends on nothing; imported by hse_exec and the top level.
`timescale 1ns / 1ps

package hse_pkg;

	// instruction forms
	localparam logic [3:0] FORM_LOAD_A   = 4'd0;
	localparam logic [3:0] FORM_SET      = 4'd1;
	localparam logic [3:0] FORM_COPY     = 4'd2;
	localparam logic [3:0] FORM_OP_REG   = 4'd3;
	localparam logic [3:0] FORM_OP_NUM   = 4'd4;
	localparam logic [3:0] FORM_JUMP     = 4'd5;
	localparam logic [3:0] FORM_JREG_OP  = 4'd6;
	localparam logic [3:0] FORM_JNUM_OP  = 4'd7;

	// register codes
	localparam logic [1:0] REG_D    = 2'd0;
	localparam logic [1:0] REG_A    = 2'd1;
	localparam logic [1:0] REG_M    = 2'd2;
	localparam logic [1:0] REG_NONE = 2'd3;

	// operation codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_AND = 3'd2;
	localparam logic [2:0] OP_OR  = 3'd3;

	// jump conditions
	localparam logic [2:0] COND_JMP = 3'd0;
	localparam logic [2:0] COND_JNE = 3'd1;
	localparam logic [2:0] COND_JEQ = 3'd2;
	localparam logic [2:0] COND_JLT = 3'd3;
	localparam logic [2:0] COND_JLE = 3'd4;
	localparam logic [2:0] COND_JGT = 3'd5;
	localparam logic [2:0] COND_JGE = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_UNMATCHED  = 3'd1;
	localparam logic [2:0] ST_BAD_FIRST  = 3'd2;
	localparam logic [2:0] ST_BAD_SECOND = 3'd3;
	localparam logic [2:0] ST_MISMATCH   = 3'd4;
	localparam logic [2:0] ST_UNKNOWN_OP = 3'd5;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [1:0]  dest_reg;
		logic [1:0]  left_reg;
		logic [1:0]  right_reg;
		logic [2:0]  alu_op;
		logic [15:0] number;
		logic [2:0]  jump_cond;
		logic [15:0] jump_target;
		logic [15:0] mem_word;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] a_value;
		logic [15:0] d_value;
		logic [15:0] m_value;
		logic [15:0] pc_value;
		logic        jump_taken;
	} rsp_t;

	// outcome flags from the execute logic
	typedef struct packed {
		logic [2:0] status;
		logic       jump_taken;
	} exec_flags_t;

endpackage

/* rtl/hse_exec.sv */
// Combinational execute logic: decode, ALU, jump test and next register values.
// Depends on hse_pkg.
`timescale 1ns / 1ps

module hse_exec
	import hse_pkg::*;
#(
	parameter int WORD_BITS = 16
) (
	input  req_t                 req,
	input  logic [WORD_BITS-1:0] a_cur,
	input  logic [WORD_BITS-1:0] d_cur,
	input  logic [WORD_BITS-1:0] m_cur,
	input  logic [15:0]          pc_cur,
	output logic [WORD_BITS-1:0] a_nxt,
	output logic [WORD_BITS-1:0] d_nxt,
	output logic [WORD_BITS-1:0] m_nxt,
	output logic [15:0]          pc_nxt,
	output exec_flags_t          flags
);

	function automatic logic [WORD_BITS-1:0] pick(input logic [1:0] code,
		input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] d,
		input logic [WORD_BITS-1:0] m);
		case (code)
			REG_D:   pick = d;
			REG_A:   pick = a;
			REG_M:   pick = m;
			default: pick = '0;
		endcase
	endfunction

	function automatic logic cond_holds(input logic [WORD_BITS-1:0] v,
		input logic [2:0] cond);
		logic zero;
		logic neg;
		zero = (v == '0);
		neg  = v[WORD_BITS-1];
		case (cond)
			COND_JMP: cond_holds = 1'b1;
			COND_JNE: cond_holds = !zero;
			COND_JEQ: cond_holds = zero;
			COND_JLT: cond_holds = neg;
			COND_JLE: cond_holds = neg || zero;
			COND_JGT: cond_holds = !neg && !zero;
			COND_JGE: cond_holds = !neg;
			default:  cond_holds = 1'b0;
		endcase
	endfunction

	logic [WORD_BITS-1:0] r1, r2, r3, num_w, mem_w, alu_y, alu_res, wr_val, cond_val;
	logic                 op_ok, wr_en, jump_en, taken;
	logic [2:0]           exec_status;

	assign r1    = pick(req.dest_reg, a_cur, d_cur, m_cur);
	assign r2    = pick(req.left_reg, a_cur, d_cur, m_cur);
	assign r3    = pick(req.right_reg, a_cur, d_cur, m_cur);
	assign num_w = WORD_BITS'(req.number);
	assign mem_w = WORD_BITS'(req.mem_word);

	// second operand of the ALU depends on the form
	always_comb begin
		case (req.req_type)
			FORM_OP_REG:  alu_y = r3;
			FORM_JREG_OP: alu_y = r2;
			default:      alu_y = num_w;
		endcase
	end

	always_comb begin
		op_ok = 1'b1;
		case (req.alu_op)
			OP_ADD:  alu_res = r1 + alu_y;
			OP_SUB:  alu_res = r1 - alu_y;
			OP_AND:  alu_res = r1 & alu_y;
			OP_OR:   alu_res = r1 | alu_y;
			default: begin
				alu_res = '0;
				op_ok   = 1'b0;
			end
		endcase
	end

	// decode form and error checks in the required priority
	always_comb begin
		exec_status = ST_OK;
		wr_en       = 1'b0;
		wr_val      = r1;
		jump_en     = 1'b0;
		cond_val    = alu_res;
		if (req.req_type == FORM_LOAD_A) begin
			// handled below
		end else if (req.req_type > FORM_JNUM_OP) begin
			exec_status = ST_UNMATCHED;
		end else if (req.dest_reg == REG_NONE) begin
			exec_status = ST_BAD_FIRST;
		end else begin
			unique case (req.req_type)
				FORM_SET: begin
					wr_en  = 1'b1;
					wr_val = num_w;
				end
				FORM_COPY: begin
					if (req.left_reg == REG_NONE) exec_status = ST_BAD_SECOND;
					else begin
						wr_en  = 1'b1;
						wr_val = r2;
					end
				end
				FORM_OP_REG: begin
					if (req.dest_reg != req.left_reg) exec_status = ST_MISMATCH;
					else if (req.right_reg == REG_NONE) exec_status = ST_BAD_SECOND;
					else if (!op_ok) exec_status = ST_UNKNOWN_OP;
					else begin
						wr_en  = 1'b1;
						wr_val = alu_res;
					end
				end
				FORM_OP_NUM: begin
					if (req.dest_reg != req.left_reg) exec_status = ST_MISMATCH;
					else if (!op_ok) exec_status = ST_UNKNOWN_OP;
					else begin
						wr_en  = 1'b1;
						wr_val = alu_res;
					end
				end
				FORM_JUMP: begin
					jump_en  = 1'b1;
					cond_val = r1;
				end
				FORM_JREG_OP: begin
					if (req.left_reg == REG_NONE) exec_status = ST_BAD_SECOND;
					else if (!op_ok) exec_status = ST_UNKNOWN_OP;
					else jump_en = 1'b1;
				end
				default: begin
					if (!op_ok) exec_status = ST_UNKNOWN_OP;
					else jump_en = 1'b1;
				end
			endcase
		end
	end

	assign taken  = jump_en && cond_holds(cond_val, req.jump_cond);
	assign flags  = '{status: exec_status, jump_taken: taken};
	assign pc_nxt = taken ? (req.jump_target - 16'd1) : pc_cur;

	always_comb begin
		a_nxt = a_cur;
		d_nxt = d_cur;
		m_nxt = m_cur;
		if (req.req_type == FORM_LOAD_A) begin
			a_nxt = num_w;
			m_nxt = mem_w;
		end else if (wr_en) begin
			case (req.dest_reg)
				REG_D:   d_nxt = wr_val;
				REG_A:   a_nxt = wr_val;
				default: m_nxt = wr_val;
			endcase
		end
	end

endmodule

/* rtl/hack_style_instruction_execute_unit.sv */
// Top level of the Hack-style instruction execute unit: input register,
// architectural registers and result register. Depends on hse_pkg, hse_exec.
`timescale 1ns / 1ps

//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  request | req_valid / req_ready | req  (hse_pkg::req_t, one instruction)
//  result  | rsp_valid / rsp_ready | rsp  (hse_pkg::rsp_t, one per instruction)
//
//  One instruction per cycle sustained while results are taken; the transfer
//  loads the input register, and the result register is loaded from it
//  when the execute stage advances, which a stalled result can hold off.
//  The register update is one add/subtract or logic op and a zero/sign test,
//  all between the input register and the result register.
//  arst_n clears A, D, M, pc and both valid flags; no clearing pass.
//  A stalled result holds the pipe; req_ready drops only while both stages
//  are full and the result is not taken.

module hack_style_instruction_execute_unit
	import hse_pkg::*;
#(
	parameter int WORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// pipeline registers
	req_t req_s1;
	logic req_valid_s1;
	rsp_t rsp_s2;
	logic rsp_valid_s2;

	// architectural state
	logic [WORD_BITS-1:0] a_q, d_q, m_q;
	logic [15:0]          pc_q;

	logic [WORD_BITS-1:0] a_nxt, d_nxt, m_nxt;
	logic [15:0]          pc_nxt;
	exec_flags_t          flags;
	logic                 advance;

	// advance the execute stage whenever the result slot is free or drains
	assign advance   = !rsp_valid_s2 || rsp_ready;
	assign req_ready = !req_valid_s1 || advance;

	hse_exec #(
		.WORD_BITS(WORD_BITS)
	) u_exec (
		.req    (req_s1),
		.a_cur  (a_q),
		.d_cur  (d_q),
		.m_cur  (m_q),
		.pc_cur (pc_q),
		.a_nxt  (a_nxt),
		.d_nxt  (d_nxt),
		.m_nxt  (m_nxt),
		.pc_nxt (pc_nxt),
		.flags  (flags)
	);

	// capture the incoming instruction on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// commit state and register the result in the same edge, so the next
	// instruction in the input register already sees the updated registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q          <= '0;
			d_q          <= '0;
			m_q          <= '0;
			pc_q         <= '0;
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= req_valid_s1;
			if (req_valid_s1) begin
				a_q  <= a_nxt;
				d_q  <= d_nxt;
				m_q  <= m_nxt;
				pc_q <= pc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid_s1) begin
			rsp_s2.status     <= flags.status;
			rsp_s2.a_value    <= 16'(a_nxt);
			rsp_s2.d_value    <= 16'(d_nxt);
			rsp_s2.m_value    <= 16'(m_nxt);
			rsp_s2.pc_value   <= pc_nxt;
			rsp_s2.jump_taken <= flags.jump_taken;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule
